/* src/pbcd_pkg.sv */
// Shared types, widths and helpers for the point/box contact detector.
package pbcd_pkg;

    localparam int COORD_W = 16;
    localparam int ROT_W   = 16;
    localparam int CFG_W   = 48;
    localparam int D_W     = COORD_W + 1;
    localparam int PROD_W  = D_W + ROT_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int FRAC_SH = ROT_W - 2;
    localparam int LOC_W   = SUM_W - FRAC_SH;
    localparam int MARG_W  = LOC_W + 2;
    localparam int IDX_W   = 3;

    localparam logic [IDX_W-1:0] REG_CENTER = 3'd0;
    localparam logic [IDX_W-1:0] REG_EXTENT = 3'd1;
    localparam logic [IDX_W-1:0] REG_COL_A  = 3'd2;
    localparam logic [IDX_W-1:0] REG_COL_B  = 3'd3;
    localparam logic [IDX_W-1:0] REG_COL_C  = 3'd4;

    localparam logic [1:0] FACE_X = 2'd0;
    localparam logic [1:0] FACE_Y = 2'd1;
    localparam logic [1:0] FACE_Z = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } t_point;

    typedef struct packed {
        logic                    in_contact;
        logic signed [COORD_W-1:0] penetration;
        logic signed [ROT_W-1:0] frame_r0c0;
        logic signed [ROT_W-1:0] frame_r0c1;
        logic signed [ROT_W-1:0] frame_r0c2;
        logic signed [ROT_W-1:0] frame_r1c0;
        logic signed [ROT_W-1:0] frame_r1c1;
        logic signed [ROT_W-1:0] frame_r1c2;
        logic signed [ROT_W-1:0] frame_r2c0;
        logic signed [ROT_W-1:0] frame_r2c1;
        logic signed [ROT_W-1:0] frame_r2c2;
    } t_result;

    typedef struct packed {
        logic [CFG_W-1:0] center;
        logic [CFG_W-1:0] extent;
        logic [CFG_W-1:0] col_a;
        logic [CFG_W-1:0] col_b;
        logic [CFG_W-1:0] col_c;
    } t_cfg;

    typedef logic [2:0][LOC_W-1:0] t_loc_vec;

    function automatic logic signed [ROT_W-1:0] rot_elem(t_cfg cfg, int col, int row);
        logic [CFG_W-1:0] c;
        case (col)
            0:       c = cfg.col_a;
            1:       c = cfg.col_b;
            default: c = cfg.col_c;
        endcase
        return $signed(c[row*ROT_W +: ROT_W]);
    endfunction

    function automatic logic signed [ROT_W-1:0] neg_sat(logic signed [ROT_W-1:0] v);
        logic signed [ROT_W-1:0] most_neg;
        most_neg = {1'b1, {(ROT_W-1){1'b0}}};
        if (v == most_neg) begin
            return {1'b0, {(ROT_W-1){1'b1}}};
        end
        return -v;
    endfunction

endpackage

/* src/pbcd_rotate.sv */
// Three-stage front end: center subtract, nine products, row sums with rounding.
module pbcd_rotate
    import pbcd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_valid,
    input  t_point   i_data,
    output logic     o_stall,
    output logic     o_valid,
    output t_loc_vec o_loc,
    input  logic     i_stall
);

    logic r_v1, r_v2, r_v3;
    logic en1, en2, en3;
    logic signed [D_W-1:0]    r_d [3];
    logic signed [PROD_W-1:0] r_p [3][3];
    t_loc_vec                 r_loc;
    logic signed [COORD_W-1:0] pt [3];
    logic signed [SUM_W-1:0]   s  [3];

    assign en3     = !r_v3 || !i_stall;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_stall = !en1;
    assign o_valid = r_v3;
    assign o_loc   = r_loc;

    assign pt[0] = i_data.point_x;
    assign pt[1] = i_data.point_y;
    assign pt[2] = i_data.point_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s[i] = SUM_W'(r_p[i][0]) + SUM_W'(r_p[i][1]) + SUM_W'(r_p[i][2])
                 + (SUM_W'(1) <<< (FRAC_SH - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            for (int k = 0; k < 3; k++) begin
                r_d[k] <= D_W'(pt[k])
                        - D_W'($signed(i_cfg.center[k*COORD_W +: COORD_W]));
            end
        end
        if (en2) begin
            for (int i = 0; i < 3; i++) begin
                for (int r = 0; r < 3; r++) begin
                    r_p[i][r] <= PROD_W'(rot_elem(i_cfg, i, r)) * PROD_W'(r_d[r]);
                end
            end
        end
        if (en3) begin
            for (int i = 0; i < 3; i++) begin
                r_loc[i] <= LOC_W'(s[i] >>> FRAC_SH);
            end
        end
    end

endmodule

/* src/pbcd_face.sv */
// Two-stage back end: inside test and margins, then face pick and frame build.
module pbcd_face
    import pbcd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_valid,
    input  t_loc_vec i_loc,
    output logic     o_stall,
    output logic     o_valid,
    output t_result  o_data,
    input  logic     i_stall
);

    logic r_v4, r_v5;
    logic en4, en5;
    logic signed [MARG_W-1:0] r_m [3];
    logic [2:0]               r_pos;
    logic                     r_inside;
    t_result                  r_res;

    logic signed [MARG_W-1:0] two [3];
    logic signed [MARG_W-1:0] ext [3];
    logic signed [MARG_W-1:0] mag [3];
    logic [2:0]               in_ax;
    t_result                  n_res;

    assign en5     = !r_v5 || !i_stall;
    assign en4     = !r_v4 || en5;
    assign o_stall = !en4;
    assign o_valid = r_v5;
    assign o_data  = r_res;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            two[i]   = MARG_W'($signed(i_loc[i])) <<< 1;
            ext[i]   = $signed(MARG_W'(i_cfg.extent[i*COORD_W +: COORD_W]));
            in_ax[i] = (two[i] <= ext[i]) && (two[i] >= -ext[i]);
            mag[i]   = (two[i] < 0) ? -two[i] : two[i];
        end
    end

    always_comb begin
        logic [1:0]               face;
        logic                     pos;
        logic signed [MARG_W-1:0] m_sel;
        logic signed [ROT_W-1:0]  a, b, c;
        logic signed [ROT_W-1:0]  fr [3][3];
        if (r_m[2] < r_m[0] && r_m[2] < r_m[1]) begin
            face = FACE_Z;
        end else if (r_m[1] < r_m[0] && r_m[1] < r_m[2]) begin
            face = FACE_Y;
        end else begin
            face = FACE_X;
        end
        case (face)
            FACE_Z:  begin pos = r_pos[2]; m_sel = r_m[2]; end
            FACE_Y:  begin pos = r_pos[1]; m_sel = r_m[1]; end
            default: begin pos = r_pos[0]; m_sel = r_m[0]; end
        endcase
        for (int r = 0; r < 3; r++) begin
            a = rot_elem(i_cfg, 0, r);
            b = rot_elem(i_cfg, 1, r);
            c = rot_elem(i_cfg, 2, r);
            case (face)
                FACE_Z: begin
                    fr[0][r] = pos ? a : neg_sat(a);
                    fr[1][r] = pos ? b : neg_sat(b);
                    fr[2][r] = pos ? c : neg_sat(c);
                end
                FACE_Y: begin
                    fr[0][r] = a;
                    fr[1][r] = pos ? neg_sat(c) : c;
                    fr[2][r] = pos ? b : neg_sat(b);
                end
                default: begin
                    fr[0][r] = pos ? b : a;
                    fr[1][r] = pos ? neg_sat(c) : b;
                    fr[2][r] = pos ? a : neg_sat(a);
                end
            endcase
        end
        n_res = '0;
        if (r_inside) begin
            n_res.in_contact  = 1'b1;
            n_res.penetration = -$signed(m_sel[COORD_W:1]);
            n_res.frame_r0c0  = fr[0][0];
            n_res.frame_r0c1  = fr[1][0];
            n_res.frame_r0c2  = fr[2][0];
            n_res.frame_r1c0  = fr[0][1];
            n_res.frame_r1c1  = fr[1][1];
            n_res.frame_r1c2  = fr[2][1];
            n_res.frame_r2c0  = fr[0][2];
            n_res.frame_r2c1  = fr[1][2];
            n_res.frame_r2c2  = fr[2][2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en4) r_v4 <= i_valid;
            if (en5) r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            for (int i = 0; i < 3; i++) begin
                r_m[i]   <= ext[i] - mag[i];
                r_pos[i] <= $signed(i_loc[i]) > 0;
            end
            r_inside <= &in_ax;
        end
        if (en5) begin
            r_res <= n_res;
        end
    end

endmodule

/* src/point_box_contact_detect.sv */
// Top level of the point/box contact detector: config registers and pipeline.
//
// Usage:
//   Input channel  (i_in_valid / o_in_stall / i_in_data): one world point per item.
//   Output channel (o_out_valid / i_out_stall / o_out_data): one contact result
//   per item, in order: flag, penetration and a 3x3 contact frame.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data):
//   0 center, 1 extent, 2..4 orientation columns; other indexes are ignored.
//   o_cfg_ready is always high; write only while no item is in flight.
// Timing:
//   Five register stages (subtract, multiply, sum/round, margins, face pick).
//   o_out_valid rises once the item has passed the face-pick stage; one item per
//   cycle while i_out_stall does not hold the pipeline.
// Reset:
//   Synchronous, active low; empties the pipeline and clears all config.
// Stall:
//   Each stage holds while its successor is full and stalled; empty stages
//   keep filling, so up to five items queue before o_in_stall rises.
module point_box_contact_detect
    import pbcd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_point           i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_result          o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);

    t_cfg     r_cfg;
    logic     mid_valid;
    logic     mid_stall;
    t_loc_vec mid_loc;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_CENTER: r_cfg.center <= i_cfg_data;
                REG_EXTENT: r_cfg.extent <= i_cfg_data;
                REG_COL_A:  r_cfg.col_a  <= i_cfg_data;
                REG_COL_B:  r_cfg.col_b  <= i_cfg_data;
                REG_COL_C:  r_cfg.col_c  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    pbcd_rotate u_rotate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .o_stall (o_in_stall),
        .o_valid (mid_valid),
        .o_loc   (mid_loc),
        .i_stall (mid_stall)
    );

    pbcd_face u_face (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (mid_valid),
        .i_loc   (mid_loc),
        .o_stall (mid_stall),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .i_stall (i_out_stall)
    );

endmodule

/* tb/pbcd_contact_checker.sv */
// Contact checker: mirrors the config registers, predicts each contact result and compares.
`timescale 1ns / 1ps
module pbcd_contact_checker
    import pbcd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  t_point           i_in_data,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  t_result          i_out_data,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic [IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending
);

    localparam longint ROT_MAX = (longint'(1) << (ROT_W - 1)) - 1;

    logic [CFG_W-1:0] box_center_q = '0;
    logic [CFG_W-1:0] box_extent_q = '0;
    logic [CFG_W-1:0] rot_cols_q [3] = '{'0, '0, '0};
    t_result          pending_contacts [$];
    int               mismatches = 0;

    function automatic logic signed [ROT_W-1:0] negate_clamped(logic signed [ROT_W-1:0] v);
        longint n;
        n = -longint'(v);
        if (n > ROT_MAX) begin
            n = ROT_MAX;
        end
        return ROT_W'(n);
    endfunction

    function automatic t_result contact_of(t_point p);
        logic signed [ROT_W-1:0]   rot [3][3];
        logic signed [ROT_W-1:0]   frm [3][3];
        logic signed [COORD_W-1:0] pt [3];
        longint                    dlt [3];
        longint                    loc [3];
        longint                    mrg [3];
        longint                    ext [3];
        longint                    acc;
        longint                    twice;
        longint                    pen;
        logic [CFG_W-1:0]          col;
        logic signed [ROT_W-1:0]   a;
        logic signed [ROT_W-1:0]   b;
        logic signed [ROT_W-1:0]   c;
        logic [1:0]                face;
        bit                        in_box;
        bit                        pos;
        t_result                   res;
        pt[0]  = p.point_x;
        pt[1]  = p.point_y;
        pt[2]  = p.point_z;
        in_box = 1'b1;
        res    = '0;
        for (int k = 0; k < 3; k++) begin
            col = rot_cols_q[k];
            for (int r = 0; r < 3; r++) begin
                rot[k][r] = $signed(col[r*ROT_W +: ROT_W]);
            end
            dlt[k] = longint'(pt[k])
                   - longint'($signed(box_center_q[k*COORD_W +: COORD_W]));
            ext[k] = longint'(box_extent_q[k*COORD_W +: COORD_W]);
        end
        for (int k = 0; k < 3; k++) begin
            acc = 0;
            for (int r = 0; r < 3; r++) begin
                acc += longint'(rot[k][r]) * dlt[r];
            end
            loc[k] = (acc + (longint'(1) << (FRAC_SH - 1))) >>> FRAC_SH;
            twice  = 2 * loc[k];
            if (twice > ext[k] || twice < -ext[k]) begin
                in_box = 1'b0;
            end
            mrg[k] = ext[k] - ((twice < 0) ? -twice : twice);
        end
        if (!in_box) begin
            return res;
        end
        if (mrg[FACE_Z] < mrg[FACE_X] && mrg[FACE_Z] < mrg[FACE_Y]) begin
            face = FACE_Z;
        end else if (mrg[FACE_Y] < mrg[FACE_X] && mrg[FACE_Y] < mrg[FACE_Z]) begin
            face = FACE_Y;
        end else begin
            face = FACE_X;
        end
        pos = loc[face] > 0;
        for (int r = 0; r < 3; r++) begin
            a = rot[0][r];
            b = rot[1][r];
            c = rot[2][r];
            case (face)
                FACE_Z: begin
                    frm[0][r] = pos ? a : negate_clamped(a);
                    frm[1][r] = pos ? b : negate_clamped(b);
                    frm[2][r] = pos ? c : negate_clamped(c);
                end
                FACE_Y: begin
                    frm[0][r] = a;
                    frm[1][r] = pos ? negate_clamped(c) : c;
                    frm[2][r] = pos ? b : negate_clamped(b);
                end
                default: begin
                    frm[0][r] = pos ? b : a;
                    frm[1][r] = pos ? negate_clamped(c) : b;
                    frm[2][r] = pos ? a : negate_clamped(a);
                end
            endcase
        end
        pen = -(mrg[face] >>> 1);
        res.in_contact  = 1'b1;
        res.penetration = COORD_W'(pen);
        res.frame_r0c0  = frm[0][0];
        res.frame_r0c1  = frm[1][0];
        res.frame_r0c2  = frm[2][0];
        res.frame_r1c0  = frm[0][1];
        res.frame_r1c1  = frm[1][1];
        res.frame_r1c2  = frm[2][1];
        res.frame_r2c0  = frm[0][2];
        res.frame_r2c1  = frm[1][2];
        res.frame_r2c2  = frm[2][2];
        return res;
    endfunction

    task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result due;
        if (!i_rst_n) begin
            box_center_q = '0;
            box_extent_q = '0;
            rot_cols_q   = '{'0, '0, '0};
            pending_contacts.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_CENTER: box_center_q  = i_cfg_data;
                    REG_EXTENT: box_extent_q  = i_cfg_data;
                    REG_COL_A:  rot_cols_q[0] = i_cfg_data;
                    REG_COL_B:  rot_cols_q[1] = i_cfg_data;
                    REG_COL_C:  rot_cols_q[2] = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                pending_contacts.push_back(contact_of(i_in_data));
            end
            if ($isunknown(i_out_valid)) begin
                $error("o_out_valid is unknown");
                mismatches++;
            end else if (i_out_valid && !i_out_stall) begin
                if (pending_contacts.size() == 0) begin
                    $error("result item with no item outstanding");
                    mismatches++;
                end else begin
                    due = pending_contacts.pop_front();
                    check_field("in_contact", due.in_contact, i_out_data.in_contact);
                    check_field("penetration", due.penetration, i_out_data.penetration);
                    check_field("frame_r0c0", due.frame_r0c0, i_out_data.frame_r0c0);
                    check_field("frame_r0c1", due.frame_r0c1, i_out_data.frame_r0c1);
                    check_field("frame_r0c2", due.frame_r0c2, i_out_data.frame_r0c2);
                    check_field("frame_r1c0", due.frame_r1c0, i_out_data.frame_r1c0);
                    check_field("frame_r1c1", due.frame_r1c1, i_out_data.frame_r1c1);
                    check_field("frame_r1c2", due.frame_r1c2, i_out_data.frame_r1c2);
                    check_field("frame_r2c0", due.frame_r2c0, i_out_data.frame_r2c0);
                    check_field("frame_r2c1", due.frame_r2c1, i_out_data.frame_r2c1);
                    check_field("frame_r2c2", due.frame_r2c2, i_out_data.frame_r2c2);
                end
            end
        end
        o_pending    <= pending_contacts.size();
        o_fail_count <= mismatches;
    end

endmodule

/* tb/point_box_contact_detect_test.sv */
// Testbench top for the point/box contact detector: box setups, point items, idling, verdict.
`timescale 1ns / 1ps
module point_box_contact_detect_test;
    import pbcd_pkg::*;

    localparam int ITEMS_PER_PHASE = 190;
    localparam int PHASES          = 9;
    localparam logic [ROT_W-1:0] UNIT = 16'h4000;

    typedef enum int {BOX_AXIS, BOX_PERM, BOX_RANDOM, BOX_EXTREME, BOX_TINY} t_box_kind;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    t_point           in_data   = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    t_result          out_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data  = '0;
    int               fail_count;
    int               pending;

    logic [COORD_W-1:0] box_mid [3]  = '{'0, '0, '0};
    logic [COORD_W-1:0] box_size [3] = '{'0, '0, '0};
    bit                 calm = 1'b0;

    point_box_contact_detect uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    pbcd_contact_checker watch (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [CFG_W-1:0] pack3(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        return {z, y, x};
    endfunction

    function automatic logic [CFG_W-1:0] axis_col(int ax, logic [ROT_W-1:0] scale);
        logic [CFG_W-1:0] col;
        col = '0;
        col[ax*ROT_W +: ROT_W] = scale;
        return col;
    endfunction

    function automatic logic [ROT_W-1:0] pick_scale();
        case ($urandom_range(0, 5))
            0:       return UNIT;
            1:       return -UNIT;
            2:       return 16'h8000;
            3:       return 16'h7FFF;
            4:       return 16'h2000;
            default: return 16'hE000;
        endcase
    endfunction

    function automatic logic [15:0] pick_extreme();
        case ($urandom_range(0, 4))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'h0001;
        endcase
    endfunction

    function automatic logic [15:0] jitter(int span);
        return 16'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic logic [CFG_W-1:0] rand_reg();
        return CFG_W'({$urandom(), $urandom()});
    endfunction

    function automatic t_point pt3(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        t_point p;
        p.point_x = x;
        p.point_y = y;
        p.point_z = z;
        return p;
    endfunction

    // Points mostly aimed at the box, some on or just past a face, the rest anywhere.
    function automatic t_point make_point();
        logic [COORD_W-1:0] q [3];
        int                 pick;
        int                 lim;
        int                 half;
        int                 off;
        pick = $urandom_range(0, 99);
        lim  = box_size[0];
        for (int k = 1; k < 3; k++) begin
            if (box_size[k] < lim) begin
                lim = box_size[k];
            end
        end
        lim = lim >> $urandom_range(1, 2);
        for (int k = 0; k < 3; k++) begin
            half = box_size[k] >> 1;
            if (pick < 65) begin
                off = int'($urandom_range(0, 2 * lim)) - lim;
            end else begin
                off = $urandom_range(0, 1) ? half : int'($urandom_range(0, 2 * lim)) - lim;
                off += int'($urandom_range(0, 1));
                if ($urandom_range(0, 1)) begin
                    off = -off;
                end
            end
            q[k] = (pick < 82) ? box_mid[k] + COORD_W'(off) : COORD_W'($urandom());
        end
        return pt3(q[0], q[1], q[2]);
    endfunction

    task automatic send_point(t_point p);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= p;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic load_box(logic [CFG_W-1:0] mid, logic [CFG_W-1:0] size,
                            logic [CFG_W-1:0] ca, logic [CFG_W-1:0] cb, logic [CFG_W-1:0] cc);
        logic [CFG_W-1:0] vals [5];
        logic [IDX_W-1:0] idx [5];
        vals = '{mid, size, ca, cb, cc};
        idx  = '{REG_CENTER, REG_EXTENT, REG_COL_A, REG_COL_B, REG_COL_C};
        for (int k = 0; k < 5; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= vals[k];
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
        end
        // unmapped index, must leave the box untouched
        if ($urandom_range(0, 1)) begin
            cfg_index <= REG_COL_C + IDX_W'($urandom_range(1, 3));
            cfg_data  <= rand_reg();
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
        end
        cfg_valid <= 1'b0;
        for (int k = 0; k < 3; k++) begin
            box_mid[k]  = mid[k*COORD_W +: COORD_W];
            box_size[k] = size[k*COORD_W +: COORD_W];
        end
    endtask

    initial begin
        int               run;
        int               hold;
        forever begin
            run = calm ? 40 : $urandom_range(1, 12);
            repeat (run) @(posedge clk);
            hold = pick_gap();
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial begin
        logic [CFG_W-1:0] mid;
        logic [CFG_W-1:0] size;
        logic [CFG_W-1:0] ca;
        logic [CFG_W-1:0] cb;
        logic [CFG_W-1:0] cc;
        t_box_kind        kind;
        int               s;
        int               ax0;
        int               ax1;
        int               ax2;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // cleared box: every point lands on a zero-size box at the origin
        send_point(pt3(16'h0000, 16'h0000, 16'h0000));
        send_point(pt3(16'h7FFF, 16'h8000, 16'h0001));
        send_point(pt3(16'h8000, 16'h7FFF, 16'hFFFF));
        drain();

        // axis-aligned box, odd x size; faces, ties and zero coordinates
        load_box(pack3(16'h0000, 16'h0000, 16'h0000), pack3(16'h2001, 16'h3000, 16'h4000),
                 axis_col(0, UNIT), axis_col(1, UNIT), axis_col(2, UNIT));
        send_point(pt3(16'h0000, 16'h0000, 16'h0000));
        send_point(pt3(16'h1000, 16'h0000, 16'h0000));
        send_point(pt3(16'hF000, 16'h0000, 16'h0000));
        send_point(pt3(16'h1001, 16'h0000, 16'h0000));
        send_point(pt3(16'h0000, 16'h1700, 16'h0000));
        send_point(pt3(16'h0000, 16'hE900, 16'h0000));
        send_point(pt3(16'h0000, 16'h0000, 16'h1F00));
        send_point(pt3(16'h0000, 16'h0000, 16'hE100));
        send_point(pt3(16'h0000, 16'h0000, 16'h2000));
        send_point(pt3(16'h0000, 16'h0000, 16'hDFFF));
        send_point(pt3(16'h0000, 16'h1700, 16'h1F00));
        send_point(pt3(16'h0F00, 16'h0000, 16'h1F00));
        send_point(pt3(16'h7FFF, 16'h7FFF, 16'h7FFF));
        send_point(pt3(16'h8000, 16'h8000, 16'h8000));
        drain();

        // widest box at extreme center, most-negative rotation entries
        load_box(pack3(16'h8000, 16'h7FFF, 16'h0000), pack3(16'hFFFF, 16'hFFFF, 16'hFFFF),
                 pack3(16'h8000, 16'h0064, 16'hFFFB), pack3(16'h0007, 16'h8000, 16'h0000),
                 pack3(16'h7FFF, 16'h0000, 16'h8000));
        send_point(pt3(16'h8000, 16'h7FFF, 16'h0000));
        send_point(pt3(16'h8001, 16'h7FFF, 16'h0000));
        send_point(pt3(16'h8000, 16'h7FFE, 16'h0000));
        send_point(pt3(16'h8000, 16'h7FFF, 16'h0003));
        send_point(pt3(16'h7FFF, 16'h8000, 16'h7FFF));
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            kind = t_box_kind'(ph % 5);
            calm = (ph % 4 == 2);
            mid  = pack3(jitter(16'h2000), jitter(16'h2000), jitter(16'h2000));
            s    = $urandom_range(16'h0200, 16'h6000);
            size = $urandom_range(0, 1) ? pack3(16'(s), 16'(s), 16'(s))
                 : pack3(16'($urandom_range(16'h0200, 16'h6000)),
                         16'($urandom_range(16'h0200, 16'h6000)),
                         16'($urandom_range(16'h0200, 16'h6000)));
            ca   = axis_col(0, UNIT);
            cb   = axis_col(1, UNIT);
            cc   = axis_col(2, UNIT);
            case (kind)
                BOX_AXIS: ;
                BOX_PERM: begin
                    ax0 = $urandom_range(0, 2);
                    ax1 = (ax0 + $urandom_range(1, 2)) % 3;
                    ax2 = 3 - ax0 - ax1;
                    ca  = axis_col(ax0, pick_scale());
                    cb  = axis_col(ax1, pick_scale());
                    cc  = axis_col(ax2, pick_scale());
                end
                BOX_RANDOM: begin
                    mid  = rand_reg();
                    size = rand_reg();
                    ca   = rand_reg();
                    cb   = rand_reg();
                    cc   = rand_reg();
                end
                BOX_EXTREME: begin
                    mid  = pack3(pick_extreme(), pick_extreme(), pick_extreme());
                    size = pack3(16'hFFFF, 16'hFFFF, 16'hFFFF);
                    ca   = pack3(pick_extreme(), pick_extreme(), pick_extreme());
                    cb   = pack3(pick_extreme(), pick_extreme(), pick_extreme());
                    cc   = pack3(pick_extreme(), pick_extreme(), pick_extreme());
                end
                BOX_TINY: begin
                    mid  = rand_reg();
                    size = pack3(16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                                 16'($urandom_range(0, 3)));
                end
                default: ;
            endcase
            load_box(mid, size, ca, cb, cc);
            repeat (ITEMS_PER_PHASE) send_point(make_point());
            drain();
        end

        calm = 1'b0;
        repeat (10) @(posedge clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
